### hdl/url_percent_encoder_top_macros.svh
// assertion macros shared by the url percent encoder modules
`ifndef URL_PERCENT_ENCODER_TOP_MACROS_SVH
`define URL_PERCENT_ENCODER_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define UPE_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("upe assertion failed");

// condition implies consequence in the next cycle
`define UPE_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("upe assertion failed");

`endif

### hdl/upe_pkg.sv
// package with payload types, escape mode codes and run kinds of the url percent encoder
`timescale 1ns / 1ps

package upe_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } rsp_type;

   localparam logic [2:0] MODE_PATH     = 3'd0;
   localparam logic [2:0] MODE_SEGMENT  = 3'd1;
   localparam logic [2:0] MODE_HOST     = 3'd2;
   localparam logic [2:0] MODE_ZONE     = 3'd3;
   localparam logic [2:0] MODE_USERINFO = 3'd4;
   localparam logic [2:0] MODE_QUERY    = 3'd5;
   localparam logic [2:0] MODE_FRAGMENT = 3'd6;

   localparam logic [0:0] REG_ESCAPE_MODE = 1'b0;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_PLUS,
      KIND_ESCAPE
   } kind_type;

   // one classified byte, as it sits in the queue
   typedef struct packed {
      logic [7:0] raw_byte;
      logic       last;
      kind_type   kind;
   } cls_type;

   // head of the queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cls_type entry;
   } head_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_HIGH,
      PH_LOW
   } phase_type;

endpackage

### hdl/url_percent_encoder_top.sv
// top level of the url percent encoder: escape mode register, front end, queue, back end
// an accepted byte goes through the front register and the queue into the output register
// throughput: one result byte per cycle while rsp_ready is high and the queue is not empty,
//   set by the output register; a passed or '+' byte gives one result byte, an escape three
// a full back end does not stop the front end until the front register and queue fill
// reset: synchronous, active high; mode back to path, queue emptied, pending result dropped
`timescale 1ns / 1ps

module url_percent_encoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   // input byte channel
   input  logic             req_valid,
   output logic             req_ready,
   input  upe_pkg::req_type req_payload,
   // result byte channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output upe_pkg::rsp_type rsp_payload,
   // register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import upe_pkg::*;

   // escape mode register, single word at byte address zero
   logic [2:0] mode_ff, mode_in;
   logic       reg_write;
   logic       reg_hit;

   // front to queue transfer
   logic     push;
   cls_type  push_entry;
   logic     queue_ready;

   // queue to back end
   head_type head;
   logic     pop;

   assign pready    = 1'b1;
   assign reg_hit   = (paddr[2] == REG_ESCAPE_MODE) && (paddr[1:0] == 2'b00);
   assign reg_write = psel && penable && pwrite && pready && reg_hit;

   // only the low three bits of the written word are kept
   always_comb begin
      mode_in = mode_ff;
      if (reg_write) begin
         mode_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PATH;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // read back; unmapped addresses read as zero
   assign prdata = reg_hit ? {29'd0, mode_ff} : 32'd0;

   // front end classifies each byte as it is taken in
   upe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .escape_mode (mode_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (queue_ready)
   );

   // decoupling queue, lets either side stall on its own
   upe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .queue_ready (queue_ready),
      .pop         (pop),
      .head        (head)
   );

   // back end expands escapes into '%' and two hex digits
   upe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/upe_front.sv
// front end: accepts raw bytes and classifies them under the current escape mode
`timescale 1ns / 1ps

module upe_front (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       escape_mode,
   input  logic             req_valid,
   output logic             req_ready,
   input  upe_pkg::req_type req_payload,
   output logic             push,
   output upe_pkg::cls_type push_entry,
   input  logic             queue_ready
);
   import upe_pkg::*;

   logic    valid_ff, valid_in;
   cls_type entry_ff, entry_in;
   logic    accept;

   function automatic logic must_escape(input logic [7:0] c, input logic [2:0] m);
      logic alnum;
      logic host_keep;
      logic reserved;
      logic res;
      alnum = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
      host_keep = 1'b0;
      case (c)
         "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=", ":",
         "[", "]", "<", ">", 8'h22: host_keep = 1'b1;
         default: host_keep = 1'b0;
      endcase
      reserved = 1'b0;
      case (c)
         "$", "&", "+", ",", "/", ":", ";", "=", "?", "@": reserved = 1'b1;
         default: reserved = 1'b0;
      endcase
      res = 1'b1;
      if (alnum) begin
         res = 1'b0;
      end else if ((m == MODE_HOST || m == MODE_ZONE) && host_keep) begin
         res = 1'b0;
      end else if (c == "-" || c == "_" || c == "." || c == "~") begin
         res = 1'b0;
      end else if (reserved && m == MODE_PATH) begin
         res = (c == "?");
      end else if (reserved && m == MODE_SEGMENT) begin
         res = (c == "/" || c == ";" || c == "," || c == "?");
      end else if (reserved && m == MODE_USERINFO) begin
         res = (c == "@" || c == "/" || c == "?" || c == ":");
      end else if (reserved && m == MODE_QUERY) begin
         res = 1'b1;
      end else if (reserved && m == MODE_FRAGMENT) begin
         res = 1'b0;
      end else if (m == MODE_FRAGMENT && (c == "!" || c == "(" || c == ")" || c == "*")) begin
         res = 1'b0;
      end
      return res;
   endfunction

   assign req_ready = !valid_ff || queue_ready;
   assign accept    = req_valid && req_ready;
   assign push      = valid_ff && queue_ready;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in          = 1'b1;
         entry_in.raw_byte = req_payload.in_byte;
         entry_in.last     = req_payload.in_last;
         if (req_payload.in_byte == " " && escape_mode == MODE_QUERY) begin
            entry_in.kind = KIND_PLUS;
         end else if (must_escape(req_payload.in_byte, escape_mode)) begin
            entry_in.kind = KIND_ESCAPE;
         end else begin
            entry_in.kind = KIND_PASS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push_entry = entry_ff;

endmodule

### hdl/upe_queue.sv
// short queue of classified bytes between the front and back ends
`timescale 1ns / 1ps

`include "url_percent_encoder_top_macros.svh"

module upe_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  upe_pkg::cls_type  push_entry,
   output logic              queue_ready,
   input  logic              pop,
   output upe_pkg::head_type head
);
   import upe_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   cls_type          store_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign queue_ready = (count_ff != CNT_W'(DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.entry  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `UPE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `UPE_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, head.valid)
   `UPE_ASSERT_NEXT(a_count_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

### hdl/upe_back.sv
// back end: turns each classified byte into one or three output bytes
`timescale 1ns / 1ps

`include "url_percent_encoder_top_macros.svh"

module upe_back (
   input  logic              clock,
   input  logic              reset,
   input  upe_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output upe_pkg::rsp_type  rsp_payload
);
   import upe_pkg::*;

   phase_type phase_ff, phase_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff, out_in;
   logic      load;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
   endfunction

   assign load = head.valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      phase_in     = phase_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      pop          = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         unique case (phase_ff)
            PH_FIRST: begin
               unique case (head.entry.kind)
                  KIND_ESCAPE: begin
                     out_in.out_byte   = "%";
                     out_in.run_end    = 1'b0;
                     out_in.string_end = 1'b0;
                     phase_in          = PH_HIGH;
                  end
                  KIND_PLUS: begin
                     out_in.out_byte   = "+";
                     out_in.run_end    = 1'b1;
                     out_in.string_end = head.entry.last;
                     pop               = 1'b1;
                  end
                  default: begin
                     out_in.out_byte   = head.entry.raw_byte;
                     out_in.run_end    = 1'b1;
                     out_in.string_end = head.entry.last;
                     pop               = 1'b1;
                  end
               endcase
            end
            PH_HIGH: begin
               out_in.out_byte   = hex_digit(head.entry.raw_byte[7:4]);
               out_in.run_end    = 1'b0;
               out_in.string_end = 1'b0;
               phase_in          = PH_LOW;
            end
            PH_LOW: begin
               out_in.out_byte   = hex_digit(head.entry.raw_byte[3:0]);
               out_in.run_end    = 1'b1;
               out_in.string_end = head.entry.last;
               phase_in          = PH_FIRST;
               pop               = 1'b1;
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `UPE_ASSERT_SAME(a_mid_run_held, clock, reset, phase_ff != PH_FIRST, head.valid)
   `UPE_ASSERT_SAME(a_open_run, clock, reset, out_valid_ff && !out_ff.run_end, phase_ff != PH_FIRST)
   `UPE_ASSERT_NEXT(a_high_to_low, clock, reset, load && phase_ff == PH_HIGH, phase_ff == PH_LOW)

endmodule
